// ----- hw/rtl/hrkr_pkg.sv -----
// Shared operation codes, command type and constants for the HID key remapper.
package hrkr_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_PRESS       = 3'd0,
    OP_RELEASE     = 3'd1,
    OP_RELEASE_ALL = 3'd2,
    OP_WRITE_RULE  = 3'd3,
    OP_SET_COUNT   = 3'd4,
    OP_REPORT      = 3'd5
  } op_t;

  localparam logic [7:0] MOD_FIRST = 8'hE0;
  localparam int         OUT_SLOTS = 6;

  // Decoded command passed from the front part to the engine
  typedef struct packed {
    op_t         op;
    logic [7:0]  key;
    logic [1:0]  slot;
    logic [31:0] rule;   // {xor, out code, match, mask}
    logic [2:0]  count;
  } cmd_t;

endpackage

// ----- hw/rtl/hrkr_if.sv -----
// Valid/ready channel interfaces for request and report transfers.
interface hrkr_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] key_code;
  logic [1:0] rule_slot;
  logic [7:0] rule_mask;
  logic [7:0] rule_match;
  logic [7:0] rule_out_code;
  logic [7:0] rule_mod_xor;
  logic [2:0] rule_count;

  modport source (output valid, operation, key_code, rule_slot, rule_mask, rule_match,
                  rule_out_code, rule_mod_xor, rule_count, input ready);
  modport sink (input valid, operation, key_code, rule_slot, rule_mask, rule_match,
                rule_out_code, rule_mod_xor, rule_count, output ready);
endinterface

interface hrkr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifiers;
  logic [7:0] key_slot_a;
  logic [7:0] key_slot_b;
  logic [7:0] key_slot_c;
  logic [7:0] key_slot_d;
  logic [7:0] key_slot_e;
  logic [7:0] key_slot_f;

  modport source (output valid, modifiers, key_slot_a, key_slot_b, key_slot_c, key_slot_d,
                  key_slot_e, key_slot_f, input ready);
  modport sink (input valid, modifiers, key_slot_a, key_slot_b, key_slot_c, key_slot_d,
                key_slot_e, key_slot_f, output ready);
endinterface

// ----- hw/rtl/hrkr_front.sv -----
// Front part: accepts items, drops those with no effect, queues the rest.
module hrkr_front import hrkr_pkg::*; #(
  parameter int KEY_CODES     = 256,
  parameter int RULES_PER_KEY = 4
) (
  input  logic          clk,
  input  logic          rst,
  hrkr_req_if.sink      req,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output cmd_t          cmd
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       key_ok;
  logic       slot_ok;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  // Classify the incoming item
  always_comb begin
    key_ok  = {1'b0, req.key_code} < 9'(KEY_CODES);
    slot_ok = int'(req.rule_slot) < RULES_PER_KEY;
    case (req.operation)
      OP_PRESS, OP_RELEASE, OP_SET_COUNT: keep = key_ok;
      OP_WRITE_RULE:                      keep = key_ok && slot_ok;
      OP_RELEASE_ALL, OP_REPORT:          keep = 1'b1;
      default:                            keep = 1'b0;
    endcase
    cmd_in.op    = op_t'(req.operation);
    cmd_in.key   = req.key_code;
    cmd_in.slot  = req.rule_slot;
    cmd_in.rule  = {req.rule_mod_xor, req.rule_out_code, req.rule_match, req.rule_mask};
    cmd_in.count = req.rule_count;
  end

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready && keep;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  // Two-entry command queue
  always_ff @(posedge clk) begin
    if (push) queue[wr_ptr] <= cmd_in;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hw/rtl/hrkr_engine.sv -----
// Back part: key bitmap, rule stores and the report scan sequencer.
module hrkr_engine import hrkr_pkg::*; #(
  parameter int KEY_CODES     = 256,
  parameter int RULES_PER_KEY = 4,
  parameter int REPORT_BYTES  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmd_t          cmd,
  hrkr_rsp_if.source    rsp
);

  localparam int KW    = $clog2(KEY_CODES);
  localparam int CW    = $clog2(RULES_PER_KEY + 1);
  localparam int AW    = $clog2(KEY_CODES * RULES_PER_KEY);
  localparam int LIMIT = REPORT_BYTES - 2;
  localparam int FW    = $clog2(REPORT_BYTES - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_KEY  = 4'b0010,
    S_RULE = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state;
  logic [KEY_CODES-1:0] pressed;
  logic [KEY_CODES-1:0] cnt_vld;
  logic [CW-1:0]       cnt_mem [KEY_CODES];
  logic [31:0]         rule_mem [KEY_CODES * RULES_PER_KEY];
  logic [CW-1:0]       cnt_q;
  logic                cnt_ok_q;
  logic [31:0]         rule_q;
  logic [KW:0]         idx;
  logic [CW-1:0]       r;
  logic [FW-1:0]       filled;
  logic [7:0]          mods;
  logic [7:0]          codes [OUT_SLOTS];
  logic [KW-1:0]       key_idx;
  logic [CW-1:0]       cnt_eff;
  logic [CW-1:0]       cnt_sat;
  logic [CW-1:0]       r_sel;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic                hit;
  logic                is_mod;
  logic [7:0]          code;
  logic                cur_pressed;

  assign key_idx     = idx[KW-1:0];
  assign cur_pressed = pressed[key_idx];
  assign cnt_eff     = cnt_ok_q ? cnt_q : '0;
  assign is_mod      = (idx >= (KW+1)'(MOD_FIRST)) && (idx < (KW+1)'(MOD_FIRST) + (KW+1)'(8));
  assign cnt_sat     = (int'(cmd.count) > RULES_PER_KEY) ? CW'(RULES_PER_KEY) : CW'(cmd.count);
  assign r_sel       = (state == S_RULE) ? r + CW'(1) : '0;
  assign raddr       = AW'(int'(key_idx) * RULES_PER_KEY + int'(r_sel));
  assign waddr       = AW'(int'(cmd.key) * RULES_PER_KEY + int'(cmd.slot));
  assign cmd_ready   = (state == S_IDLE);

  // Rule evaluation for the current key
  always_comb begin
    hit  = (r < cnt_eff) && ((mods & rule_q[7:0]) == rule_q[15:8]);
    code = hit ? rule_q[23:16] : (is_mod ? 8'd0 : idx[7:0]);
  end

  // Rule and count stores
  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd_valid && cmd.op == OP_WRITE_RULE) rule_mem[waddr] <= cmd.rule;
    rule_q <= rule_mem[raddr];
    if (state == S_IDLE && cmd_valid && cmd.op == OP_SET_COUNT) cnt_mem[cmd.key[KW-1:0]] <= cnt_sat;
    if (state == S_KEY) cnt_q <= cnt_mem[key_idx];
  end

  // Command execution and report scan
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pressed   <= '0;
      cnt_vld   <= '0;
      cnt_ok_q  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              OP_PRESS:       pressed[cmd.key[KW-1:0]] <= 1'b1;
              OP_RELEASE:     pressed[cmd.key[KW-1:0]] <= 1'b0;
              OP_RELEASE_ALL: pressed <= '0;
              OP_SET_COUNT:   cnt_vld[cmd.key[KW-1:0]] <= 1'b1;
              OP_REPORT: begin
                mods   <= pressed[int'(MOD_FIRST) +: 8];
                idx    <= '0;
                filled <= '0;
                for (int k = 0; k < OUT_SLOTS; k++) codes[k] <= 8'd0;
                state  <= S_KEY;
              end
              default: ;
            endcase
          end
        end
        S_KEY: begin
          if (idx == (KW+1)'(KEY_CODES) || int'(filled) == LIMIT) begin
            state <= S_DONE;
          end else if (cur_pressed) begin
            cnt_ok_q <= cnt_vld[key_idx];
            r        <= '0;
            state    <= S_RULE;
          end else begin
            idx <= idx + (KW+1)'(1);
          end
        end
        S_RULE: begin
          if (hit || !(r < cnt_eff)) begin
            if (hit) mods <= mods ^ rule_q[31:24];
            if (code != 8'd0) begin
              for (int k = 0; k < OUT_SLOTS; k++)
                if (int'(filled) == k) codes[k] <= code;
              filled <= filled + FW'(1);
            end
            idx   <= idx + (KW+1)'(1);
            state <= S_KEY;
          end else begin
            r <= r + CW'(1);
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.modifiers  <= mods;
            rsp.key_slot_a <= codes[0];
            rsp.key_slot_b <= codes[1];
            rsp.key_slot_c <= codes[2];
            rsp.key_slot_d <= codes[3];
            rsp.key_slot_e <= codes[4];
            rsp.key_slot_f <= codes[5];
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/hid_report_key_remapper.sv -----
// Top level of the HID report key remapper.
//
//   channel  dir  carries
//   req      in   operation, key code and rule fields
//   rsp      out  modifier byte and six key codes
//
// Key and rule commands are executed in the engine's idle state. A report scans
// the key bitmap in order and, for every pressed key, steps through its rules
// until one matches or none is left, one rule at a time through the registered
// rule store read port. Reset is synchronous and clears the bitmap and count
// valid bits at once. A two-entry queue lets the request side run on while the
// engine scans or waits for the report to be taken.
module hid_report_key_remapper import hrkr_pkg::*; #(
  parameter int KEY_CODES     = 256,
  parameter int RULES_PER_KEY = 4,
  parameter int REPORT_BYTES  = 8
) (
  input  logic       clk,
  input  logic       rst,
  hrkr_req_if.sink   req,
  hrkr_rsp_if.source rsp
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  hrkr_front #(
    .KEY_CODES     (KEY_CODES),
    .RULES_PER_KEY (RULES_PER_KEY)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  hrkr_engine #(
    .KEY_CODES     (KEY_CODES),
    .RULES_PER_KEY (RULES_PER_KEY),
    .REPORT_BYTES  (REPORT_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule

// ----- sim/hid_report_key_remapper_test.sv -----
// Self-checking testbench for the HID report key remapper: directed table, then random traffic.
`timescale 1ns / 100ps

module hid_report_key_remapper_test;
  import hrkr_pkg::*;

  localparam int N_KEYS    = 256;
  localparam int N_RULES   = 4;
  localparam int N_RANDOM  = 530;
  localparam int N_DIRECT  = 20;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] key;
    logic [1:0] slot;
    logic [7:0] mask;
    logic [7:0] match;
    logic [7:0] ocode;
    logic [7:0] mxor;
    logic [2:0] count;
  } req_t;

  typedef struct packed {
    logic [7:0]      mods;
    logic [5:0][7:0] codes;   // codes[0] is slot a
  } report_t;

  typedef struct packed {
    req_t    stim;
    logic    typed;   // expected report given in the row
    report_t rpt;
  } row_t;

  logic clk;
  logic rst;

  hrkr_req_if req ();
  hrkr_rsp_if rsp ();

  hid_report_key_remapper u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Predictor state
  logic        key_down [N_KEYS];
  logic [2:0]  rules_on [N_KEYS];
  logic [31:0] rule_mem [N_KEYS*N_RULES];
  logic        rule_set [N_KEYS*N_RULES];

  report_t report_q [$];
  int      mismatches;
  int      src_idle_pct;
  int      snk_idle_pct;
  logic    stop_sink;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic is_mod_key(int code);
    return code >= int'(MOD_FIRST) && code < int'(MOD_FIRST) + 8;
  endfunction

  // Compute the report the remapper should build from the current state
  function automatic report_t build_report();
    report_t r;
    int      filled;
    logic    hit;
    logic [7:0]  code;
    logic [31:0] e;
    r = '0;
    filled = 0;
    for (int k = 0; k < 8; k++)
      if (key_down[int'(MOD_FIRST) + k]) r.mods[k] = 1'b1;
    for (int i = 0; i < N_KEYS && filled < OUT_SLOTS; i++) begin
      if (!key_down[i]) continue;
      hit = 1'b0;
      code = 8'd0;
      for (int j = 0; j < rules_on[i]; j++) begin
        e = rule_mem[i*N_RULES + j];
        if ((r.mods & e[7:0]) == e[15:8]) begin
          r.mods = r.mods ^ e[31:24];
          code = e[23:16];
          hit = 1'b1;
          break;
        end
      end
      if (!hit && !is_mod_key(i)) code = i[7:0];
      if (code != 8'd0) begin
        r.codes[filled] = code;
        filled++;
      end
    end
    return r;
  endfunction

  // Apply one accepted transfer to the predictor; queue a report if one is due
  task automatic apply_item(input req_t s, input logic typed, input report_t given);
    int n;
    report_t r;
    case (s.op)
      OP_PRESS:       key_down[s.key] = 1'b1;
      OP_RELEASE:     key_down[s.key] = 1'b0;
      OP_RELEASE_ALL: foreach (key_down[i]) key_down[i] = 1'b0;
      OP_WRITE_RULE: begin
        rule_mem[s.key*N_RULES + s.slot] = {s.mxor, s.ocode, s.match, s.mask};
        rule_set[s.key*N_RULES + s.slot] = 1'b1;
      end
      OP_SET_COUNT: begin
        n = (s.count > N_RULES) ? N_RULES : s.count;
        rules_on[s.key] = n[2:0];
      end
      OP_REPORT: begin
        r = build_report();
        if (typed && r != given) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row disagrees with predictor: row %h pred %h", given, r);
        end
        report_q.push_back(typed ? given : r);
      end
      default: ;
    endcase
  endtask

  // Count may only cover slots already written
  function automatic logic [2:0] safe_count(logic [7:0] key, logic [2:0] want);
    int n;
    n = 0;
    while (n < want && n < N_RULES && rule_set[key*N_RULES + n]) n++;
    return (want > N_RULES && n == N_RULES) ? want : n[2:0];
  endfunction

  // Offer one item; valid stays up after the transfer until the next call or idle
  task automatic send(input req_t s, input logic typed, input report_t given);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.operation     <= s.op;
    req.key_code      <= s.key;
    req.rule_slot     <= s.slot;
    req.rule_mask     <= s.mask;
    req.rule_match    <= s.match;
    req.rule_out_code <= s.ocode;
    req.rule_mod_xor  <= s.mxor;
    req.rule_count    <= s.count;
    do @(posedge clk); while (!req.ready);
    apply_item(s, typed, given);
  endtask

  function automatic req_t rand_item();
    req_t s;
    int   p;
    s = req_t'({$urandom, 24'($urandom)});
    p = $urandom_range(99);
    // keys near the modifier block and low codes get most of the traffic
    if ($urandom_range(1)) s.key = $urandom_range(1) ? 8'(8'hE0 + $urandom_range(7))
                                                       : 8'($urandom_range(12));
    if (p < 30)      s.op = OP_PRESS;
    else if (p < 50) s.op = OP_RELEASE;
    else if (p < 53) s.op = OP_RELEASE_ALL;
    else if (p < 68) s.op = OP_WRITE_RULE;
    else if (p < 76) s.op = OP_SET_COUNT;
    else if (p < 97) s.op = OP_REPORT;
    else             s.op = 3'(3'd6 + $urandom_range(1));
    if (s.op == OP_SET_COUNT) s.count = safe_count(s.key, s.count);
    return s;
  endfunction

  // Report sink: random stalls, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected report %h", {rsp.modifiers});
        end else if ({rsp.modifiers, rsp.key_slot_f, rsp.key_slot_e, rsp.key_slot_d,
                      rsp.key_slot_c, rsp.key_slot_b, rsp.key_slot_a} !=
                     report_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("report mismatch: exp %h got %h %h %h %h %h %h %h", report_q[0],
                     rsp.modifiers, rsp.key_slot_f, rsp.key_slot_e, rsp.key_slot_d,
                     rsp.key_slot_c, rsp.key_slot_b, rsp.key_slot_a);
          void'(report_q.pop_front());
        end else begin
          void'(report_q.pop_front());
        end
      end
      rsp.ready <= !stop_sink && $urandom_range(99) >= snk_idle_pct;
    end
  end

  function automatic req_t mk(logic [2:0] op, logic [7:0] key, logic [1:0] slot = 0,
                              logic [7:0] mask = 0, logic [7:0] match = 0,
                              logic [7:0] ocode = 0, logic [7:0] mxor = 0,
                              logic [2:0] count = 0);
    return '{op, key, slot, mask, match, ocode, mxor, count};
  endfunction

  function automatic report_t rp(logic [7:0] m, logic [7:0] a = 0, logic [7:0] b = 0,
                                 logic [7:0] c = 0, logic [7:0] d = 0,
                                 logic [7:0] e = 0, logic [7:0] f = 0);
    return '{m, {f, e, d, c, b, a}};
  endfunction

  row_t dir_tab [N_DIRECT];

  initial begin
    int drained;
    mismatches = 0;
    stop_sink = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    foreach (key_down[i]) begin
      key_down[i] = 1'b0;
      rules_on[i] = 3'd0;
    end
    foreach (rule_mem[i]) begin
      rule_mem[i] = '0;
      rule_set[i] = 1'b0;
    end
    req.valid <= 1'b0;
    {req.operation, req.key_code, req.rule_slot, req.rule_mask, req.rule_match,
     req.rule_out_code, req.rule_mod_xor, req.rule_count} <= '0;
    rst <= 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed table: empty report, extremes, modifier handling, rules, overflow
    dir_tab = '{
      '{mk(OP_REPORT, 8'h00), 1'b1, rp(8'h00)},
      '{mk(OP_PRESS, 8'hFF), 1'b0, '0},
      '{mk(OP_PRESS, 8'h00), 1'b0, '0},
      '{mk(OP_PRESS, 8'hE0), 1'b0, '0},
      '{mk(OP_PRESS, 8'hE7), 1'b0, '0},
      '{mk(OP_REPORT, 8'h00), 1'b1, rp(8'h81, 8'hFF)},
      '{mk(OP_WRITE_RULE, 8'h04, 2'd0, 8'hFF, 8'h81, 8'h1E, 8'h80), 1'b0, '0},
      '{mk(OP_WRITE_RULE, 8'h04, 2'd1, 8'h00, 8'h00, 8'h00, 8'hFF), 1'b0, '0},
      '{mk(OP_WRITE_RULE, 8'h04, 2'd2, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b0, '0},
      '{mk(OP_WRITE_RULE, 8'h04, 2'd3, 8'h01, 8'h00, 8'h05, 8'h01), 1'b0, '0},
      '{mk(OP_SET_COUNT, 8'h04, 0, 0, 0, 0, 0, 3'd7), 1'b0, '0},
      '{mk(OP_PRESS, 8'h04), 1'b0, '0},
      '{mk(OP_REPORT, 8'h00), 1'b1, rp(8'h01, 8'h1E, 8'hFF)},
      '{mk(OP_RELEASE, 8'hE7), 1'b0, '0},
      '{mk(OP_REPORT, 8'h00), 1'b0, '0},
      '{mk(3'd6, 8'h10), 1'b0, '0},
      '{mk(3'd7, 8'h11), 1'b0, '0},
      '{mk(OP_SET_COUNT, 8'h04, 0, 0, 0, 0, 0, 3'd0), 1'b0, '0},
      '{mk(OP_RELEASE_ALL, 8'h00), 1'b0, '0},
      '{mk(OP_REPORT, 8'h00), 1'b1, rp(8'h00)}
    };
    foreach (dir_tab[i]) send(dir_tab[i].stim, dir_tab[i].typed, dir_tab[i].rpt);

    // Many pressed keys so the six-code cut-off is hit
    for (int k = 1; k <= 9; k++) send(mk(OP_PRESS, k[7:0]), 1'b0, '0);
    send(mk(OP_REPORT, 8'h00), 1'b0, '0);

    // Long receiver hold-off while the sender keeps offering reports
    stop_sink = 1'b1;
    fork
      begin
        repeat (2000) @(posedge clk);
        stop_sink = 1'b0;
      end
      for (int k = 0; k < 6; k++) send(mk(OP_REPORT, 8'h00), 1'b0, '0);
    join
    req.valid <= 1'b0;

    // Sender pauses until every report has come
    while (report_q.size() != 0) @(posedge clk);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 83 : 0;
      snk_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 10 : 0;
      for (int n = 0; n < N_RANDOM / 3; n++) send(rand_item(), 1'b0, '0);
    end
    req.valid <= 1'b0;

    drained = 0;
    while (report_q.size() != 0 && drained < 200000) begin
      @(posedge clk);
      drained++;
    end
    repeat (1000) @(posedge clk);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/hrkr_pkg.sv
hw/rtl/hrkr_if.sv
hw/rtl/hrkr_front.sv
hw/rtl/hrkr_engine.sv
hw/rtl/hid_report_key_remapper.sv
sim/hid_report_key_remapper_test.sv
